>>> hw/rtl/stl_pkg.sv
// Shared types, constants and helper functions of the source token lexer.
// Used by the lexer top level, front end and back end; depends on nothing else.
package stl_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int LENGTH_BITS = 8;
   localparam int LIMIT_BITS = 16;
   localparam logic [LIMIT_BITS-1:0] TOKEN_LIMIT_RESET = 16'd1000;
   localparam int KW_COUNT = 4;

   typedef enum logic [1:0] {
      ST_TOKEN    = 2'd0,
      ST_FINISH   = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      K_LPAREN  = 4'd0,
      K_RPAREN  = 4'd1,
      K_LBRACE  = 4'd2,
      K_RBRACE  = 4'd3,
      K_WHILE   = 4'd4,
      K_RETURN  = 4'd5,
      K_EQUAL   = 4'd6,
      K_COMMA   = 4'd7,
      K_SEMI    = 4'd8,
      K_TYPE    = 4'd9,
      K_IDENT   = 4'd10,
      K_OP      = 4'd11,
      K_NUMBER  = 4'd12,
      K_INVALID = 4'd13
   } kind_type;

   typedef enum logic [2:0] {
      M_IDLE    = 3'd0,
      M_SLASH   = 3'd1,
      M_COMMENT = 3'd2,
      M_BANG    = 3'd3,
      M_NUMBER  = 3'd4,
      M_IDENT   = 3'd5,
      M_HALT    = 3'd6
   } mode_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } lexer_req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [3:0]             token_kind;
      logic [OFFSET_BITS-1:0] start_offset;
      logic [LENGTH_BITS-1:0] lexeme_length;
      logic [7:0]             bad_char;
      logic                   last_result;
   } lexer_rsp_type;

   typedef struct packed {
      logic     is_space;
      logic     is_slash;
      logic     is_bang;
      logic     is_equal;
      logic     is_digit;
      logic     is_alpha;
      logic     is_word;
      logic     is_single;
      kind_type single_kind;
   } byte_class_type;

   typedef struct packed {
      logic [7:0]             text_byte;
      logic                   end_of_input;
      byte_class_type         cls;
      logic [OFFSET_BITS-1:0] offset;
   } lex_item_type;

   localparam logic [47:0] KW_WORD [KW_COUNT] = '{"while", "return", "int", "void"};
   localparam int KW_LEN [KW_COUNT] = '{5, 6, 3, 4};
   localparam kind_type KW_KIND [KW_COUNT] = '{K_WHILE, K_RETURN, K_TYPE, K_TYPE};

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      c = '0;
      c.is_space = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
      c.is_slash = (b == "/");
      c.is_bang  = (b == "!");
      c.is_equal = (b == "=");
      c.is_digit = (b >= "0" && b <= "9");
      c.is_alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
      c.is_word  = c.is_alpha || c.is_digit || (b == "_");
      c.is_single = !(c.is_space || c.is_slash || c.is_bang || c.is_digit || c.is_alpha);
      case (b)
         "(": c.single_kind = K_LPAREN;
         ")": c.single_kind = K_RPAREN;
         "{": c.single_kind = K_LBRACE;
         "}": c.single_kind = K_RBRACE;
         "=": c.single_kind = K_EQUAL;
         ",": c.single_kind = K_COMMA;
         ";": c.single_kind = K_SEMI;
         "+", "*", "%": c.single_kind = K_OP;
         default: c.single_kind = K_INVALID;
      endcase
      return c;
   endfunction

   // Keeps the bit of each keyword whose next character matches the byte.
   function automatic logic [KW_COUNT-1:0] kw_advance(input logic [KW_COUNT-1:0] mask,
                                                      input logic [LENGTH_BITS-1:0] pos,
                                                      input logic [7:0] b);
      logic [KW_COUNT-1:0] nxt;
      int sh;
      nxt = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (mask[k] && (int'(pos) < KW_LEN[k])) begin
            sh = 8 * (KW_LEN[k] - 1 - int'(pos));
            nxt[k] = (KW_WORD[k][sh +: 8] == b);
         end
      end
      return nxt;
   endfunction

   function automatic kind_type ident_kind(input logic [KW_COUNT-1:0] mask,
                                           input logic [LENGTH_BITS-1:0] len);
      kind_type kind;
      kind = K_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (mask[k] && (len == LENGTH_BITS'(KW_LEN[k]))) begin
            kind = KW_KIND[k];
         end
      end
      return kind;
   endfunction

endpackage

>>> hw/rtl/source_token_lexer_unit.sv
// Source token lexer, top level: byte channel in, token channel out, limit register.
// Depends on stl_pkg, stl_front, stl_queue and stl_back.
//
// Usage. Source bytes arrive as beats on req_data with push/full; a beat with
// end_of_input set closes the text. Result beats leave on rsp_data with
// empty/pop, oldest first. The token limit is written on csr_data with
// csr_valid/csr_ready; the user must write it only while the block is idle,
// which the block itself does not enforce; csr_ready is always high.
// The result of a byte passes from the item queue through the scanning state
// machine into the result queue. Throughput: one byte per cycle while the result
// queue has room, except that a byte which ends a pending number, identifier,
// lone slash or lone bang holds the scanning state machine: it first emits the
// pending token and then handles the byte itself; the end of input after a
// pending token behaves the same way. The result queue drains at most one beat per cycle.
// Reset clears both queues and the scanner and sets the token limit to 1000.
// When the receiver does not pop, the result queue fills, the scanner stops,
// the item queue fills and full rises; nothing is lost. After a finish or
// overflow beat every further byte is taken and dropped until reset.
module source_token_lexer_unit
   import stl_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  lexer_req_type         req_data,
   output logic                  empty,
   input  logic                  pop,
   output lexer_rsp_type         rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LIMIT_BITS-1:0] csr_data
);

   localparam int ITEM_BITS = $bits(lex_item_type);
   localparam int RSP_BITS  = $bits(lexer_rsp_type);

   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic                  accept;
   lex_item_type          front_item, back_item;
   logic                  item_empty, item_pop;
   logic                  res_full, res_push;
   lexer_rsp_type         res_data;
   logic [ITEM_BITS-1:0]  item_bits;
   logic [RSP_BITS-1:0]   rsp_bits;

   assign csr_ready = 1'b1;
   assign accept    = push && !full;
   assign limit_in  = (csr_valid && csr_ready) ? csr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= TOKEN_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   stl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .item     (front_item)
   );

   stl_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (full),
      .pop       (item_pop),
      .pop_data  (item_bits),
      .empty     (item_empty)
   );

   assign back_item = lex_item_type'(item_bits);

   stl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .token_limit (limit_ff),
      .in_valid    (!item_empty),
      .in_item     (back_item),
      .in_pop      (item_pop),
      .res_full    (res_full),
      .res_push    (res_push),
      .res_data    (res_data)
   );

   stl_queue #(
      .WIDTH (RSP_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (rsp_bits),
      .empty     (empty)
   );

   assign rsp_data = lexer_rsp_type'(rsp_bits);

endmodule

>>> hw/rtl/stl_queue.sv
// Small first-in first-out queue of packed beats, used on both sides of the lexer.
// Depends on nothing but its parameters.
module stl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/stl_front.sv
// Front end of the lexer: takes source bytes, classifies them and tags their offset.
// Depends on stl_pkg.
module stl_front
   import stl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  lexer_req_type req_data,
   output lex_item_type  item
);

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;

   always_comb begin
      pos_in = pos_ff;
      if (accept && !req_data.end_of_input) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_comb begin
      item.text_byte    = req_data.text_byte;
      item.end_of_input = req_data.end_of_input;
      item.cls          = classify(req_data.text_byte);
      item.offset       = pos_ff;
   end

endmodule

>>> hw/rtl/stl_back.sv
// Back end of the lexer: the scanning state machine that builds tokens and results.
// Depends on stl_pkg; fed from the item queue, drives the result queue.
module stl_back
   import stl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [LIMIT_BITS-1:0] token_limit,
   input  logic                  in_valid,
   input  lex_item_type          in_item,
   output logic                  in_pop,
   input  logic                  res_full,
   output logic                  res_push,
   output lexer_rsp_type         res_data
);

   mode_type               mode_ff, mode_in;
   logic [KW_COUNT-1:0]    kw_ff, kw_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in, len_inc;
   logic [LIMIT_BITS-1:0]  count_ff, count_in;

   logic                   pending, cont, eoi;
   logic                   emit_req, emit_last;
   kind_type               emit_kind;
   logic [OFFSET_BITS-1:0] emit_start;
   logic [LENGTH_BITS-1:0] emit_len;
   logic [7:0]             emit_bad;
   byte_class_type         cls;

   assign cls     = in_item.cls;
   assign eoi     = in_item.end_of_input;
   assign len_inc = (len_ff == '1) ? len_ff : len_ff + 1'b1;

   always_comb begin
      pending = 1'b1;
      cont    = 1'b0;
      case (mode_ff)
         M_SLASH:  cont = !eoi && cls.is_slash;
         M_BANG:   cont = !eoi && cls.is_equal;
         M_NUMBER: cont = !eoi && cls.is_digit;
         M_IDENT:  cont = !eoi && cls.is_word;
         default:  pending = 1'b0;
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      kw_in      = kw_ff;
      start_in   = start_ff;
      len_in     = len_ff;
      count_in   = count_ff;
      in_pop     = 1'b0;
      res_push   = 1'b0;
      res_data   = '0;
      emit_req   = 1'b0;
      emit_last  = 1'b1;
      emit_kind  = K_INVALID;
      emit_start = start_ff;
      emit_len   = LENGTH_BITS'(1);
      emit_bad   = '0;
      if (in_valid && !res_full) begin
         if (mode_ff == M_HALT) begin
            in_pop = 1'b1;
         end else if (pending && !cont) begin
            // The pending token ends here; the item itself stays in the queue and is handled afterwards.
            mode_in   = M_IDLE;
            emit_req  = 1'b1;
            emit_last = !(eoi || cls.is_single);
            case (mode_ff)
               M_SLASH: begin
                  emit_bad = "/";
               end
               M_BANG: begin
                  emit_bad = "!";
               end
               M_NUMBER: begin
                  emit_kind = K_NUMBER;
                  emit_len  = len_ff;
               end
               default: begin
                  emit_kind = ident_kind(kw_ff, len_ff);
                  emit_len  = len_ff;
               end
            endcase
         end else begin
            in_pop = 1'b1;
            if (eoi) begin
               mode_in              = M_HALT;
               res_push             = 1'b1;
               res_data.status      = ST_FINISH;
               res_data.last_result = 1'b1;
            end else begin
               case (mode_ff)
                  M_COMMENT: begin
                     if (in_item.text_byte == 8'd10) begin
                        mode_in = M_IDLE;
                     end
                  end
                  M_SLASH: begin
                     mode_in = M_COMMENT;
                  end
                  M_BANG: begin
                     mode_in   = M_IDLE;
                     emit_req  = 1'b1;
                     emit_kind = K_OP;
                     emit_len  = LENGTH_BITS'(2);
                  end
                  M_NUMBER: begin
                     len_in = len_inc;
                  end
                  M_IDENT: begin
                     kw_in  = kw_advance(kw_ff, len_ff, in_item.text_byte);
                     len_in = len_inc;
                  end
                  default: begin
                     start_in = in_item.offset;
                     len_in   = LENGTH_BITS'(1);
                     if (cls.is_slash) begin
                        mode_in = M_SLASH;
                     end else if (cls.is_bang) begin
                        mode_in = M_BANG;
                     end else if (cls.is_digit) begin
                        mode_in = M_NUMBER;
                     end else if (cls.is_alpha) begin
                        mode_in = M_IDENT;
                        kw_in   = kw_advance('1, '0, in_item.text_byte);
                     end else if (cls.is_single) begin
                        emit_req   = 1'b1;
                        emit_kind  = cls.single_kind;
                        emit_start = in_item.offset;
                        if (cls.single_kind == K_INVALID) begin
                           emit_bad = in_item.text_byte;
                        end
                     end
                  end
               endcase
            end
         end
      end
      if (emit_req) begin
         res_push = 1'b1;
         if (count_ff >= token_limit) begin
            res_data.status      = ST_OVERFLOW;
            res_data.last_result = 1'b1;
            mode_in              = M_HALT;
         end else begin
            res_data.status        = ST_TOKEN;
            res_data.token_kind    = emit_kind;
            res_data.start_offset  = emit_start;
            res_data.lexeme_length = emit_len;
            res_data.bad_char      = emit_bad;
            res_data.last_result   = emit_last;
            count_in               = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         kw_ff    <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         kw_ff    <= kw_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_HALT |=> mode_ff == M_HALT)
      else $error("Lexer left the halted state without a reset.");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full && in_valid)
      else $error("Result beat written without an item or without room.");

   a_stop_after_end: assert property (@(posedge clock) disable iff (reset)
      res_push && (res_data.status == ST_OVERFLOW || res_data.status == ST_FINISH)
      |-> res_data.last_result ##1 mode_ff == M_HALT)
      else $error("Finish or overflow beat did not halt the lexer.");

   a_flush_keeps_item: assert property (@(posedge clock) disable iff (reset)
      in_valid && !res_full && !in_pop |=> in_valid && $stable(in_item))
      else $error("Item lost while a pending token was flushed.");
`endif

endmodule

>>> test/source_token_lexer_unit_tb.sv
// Testbench for source_token_lexer_unit: streams source bytes in, predicts every token
// beat with a scanner of its own and checks each popped beat against that prediction.
// Depends on stl_pkg and the lexer RTL; needs no files or arguments.
module source_token_lexer_unit_tb;
   import stl_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int STALL_PCT = 28;
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 16;
   localparam int REPORT_MAX = 10;
   localparam int RANDOM_ITEMS = 310;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   lexer_req_type req_data = '0;
   logic empty;
   logic pop = 1'b0;
   lexer_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LIMIT_BITS-1:0] csr_data = '0;

   bit steady = 1'b0;
   int error_count = 0;
   int quiet_cycles = 0;
   int sent_count = 0;

   mode_type scan_mode = M_IDLE;
   logic [KW_COUNT-1:0] kw_live = '0;
   logic [OFFSET_BITS-1:0] tok_start = '0;
   logic [LENGTH_BITS-1:0] tok_len = '0;
   logic [OFFSET_BITS-1:0] byte_pos = '0;
   int tokens_out = 0;
   int token_limit = int'(TOKEN_LIMIT_RESET);
   lexer_rsp_type step_tokens [2];
   int step_count;
   lexer_rsp_type expected_tokens [$];

   string kw_text [KW_COUNT] = '{"while", "return", "int", "void"};
   kind_type kw_kinds [KW_COUNT] = '{K_WHILE, K_RETURN, K_TYPE, K_TYPE};
   string digit_set = "0123456789";
   string letter_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   string word_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
   string punct_set = "(){}=,;+*%";
   string blank_set = "\t\n\013\014\r ";

   source_token_lexer_unit DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #(HALF_PERIOD) clock = !clock;

   function automatic bit is_blank(input logic [7:0] b);
      return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic bit is_num(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic [7:0] pick_char(input string set);
      return set[$urandom_range(set.len() - 1)];
   endfunction

   function automatic void add_token(input status_type st, input kind_type kind,
                                     input logic [OFFSET_BITS-1:0] start,
                                     input logic [LENGTH_BITS-1:0] len,
                                     input logic [7:0] bad);
      lexer_rsp_type r;
      r.status = st;
      r.token_kind = kind;
      r.start_offset = start;
      r.lexeme_length = len;
      r.bad_char = bad;
      r.last_result = 1'b0;
      step_tokens[step_count] = r;
      step_count++;
   endfunction

   function automatic void emit_token(input kind_type kind, input logic [OFFSET_BITS-1:0] start,
                                      input logic [LENGTH_BITS-1:0] len, input logic [7:0] bad);
      if (scan_mode == M_HALT) return;
      if (tokens_out >= token_limit) begin
         add_token(ST_OVERFLOW, K_LPAREN, '0, '0, 8'h00);
         scan_mode = M_HALT;
      end else begin
         add_token(ST_TOKEN, kind, start, len, bad);
         tokens_out++;
      end
   endfunction

   function automatic logic [KW_COUNT-1:0] next_kw(input logic [KW_COUNT-1:0] mask,
                                                   input logic [LENGTH_BITS-1:0] pos,
                                                   input logic [7:0] b);
      logic [KW_COUNT-1:0] nxt;
      nxt = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (mask[k] && int'(pos) < kw_text[k].len()) nxt[k] = (kw_text[k][int'(pos)] == b);
      end
      return nxt;
   endfunction

   function automatic kind_type word_kind();
      for (int k = 0; k < KW_COUNT; k++) begin
         if (kw_live[k] && tok_len == LENGTH_BITS'(kw_text[k].len())) return kw_kinds[k];
      end
      return K_IDENT;
   endfunction

   function automatic void flush_token();
      mode_type m;
      m = scan_mode;
      scan_mode = M_IDLE;
      case (m)
         M_SLASH: emit_token(K_INVALID, tok_start, 1, "/");
         M_BANG: emit_token(K_INVALID, tok_start, 1, "!");
         M_NUMBER: emit_token(K_NUMBER, tok_start, tok_len, 8'h00);
         M_IDENT: emit_token(word_kind(), tok_start, tok_len, 8'h00);
         default: ;
      endcase
   endfunction

   function automatic void open_token(input logic [7:0] b);
      if (is_blank(b)) return;
      if (b == "/" || b == "!" || is_num(b) || is_letter(b)) begin
         tok_start = byte_pos;
         tok_len = 1;
         if (b == "/") scan_mode = M_SLASH;
         else if (b == "!") scan_mode = M_BANG;
         else if (is_num(b)) scan_mode = M_NUMBER;
         else begin
            scan_mode = M_IDENT;
            kw_live = next_kw('1, '0, b);
         end
      end else begin
         case (b)
            "(": emit_token(K_LPAREN, byte_pos, 1, 8'h00);
            ")": emit_token(K_RPAREN, byte_pos, 1, 8'h00);
            "{": emit_token(K_LBRACE, byte_pos, 1, 8'h00);
            "}": emit_token(K_RBRACE, byte_pos, 1, 8'h00);
            "=": emit_token(K_EQUAL, byte_pos, 1, 8'h00);
            ",": emit_token(K_COMMA, byte_pos, 1, 8'h00);
            ";": emit_token(K_SEMI, byte_pos, 1, 8'h00);
            "+", "*", "%": emit_token(K_OP, byte_pos, 1, 8'h00);
            default: emit_token(K_INVALID, byte_pos, 1, b);
         endcase
      end
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      bit held;
      held = 1'b0;
      case (scan_mode)
         M_COMMENT: begin
            if (b == "\n") scan_mode = M_IDLE;
            held = 1'b1;
         end
         M_SLASH: if (b == "/") begin
            scan_mode = M_COMMENT;
            held = 1'b1;
         end
         M_BANG: if (b == "=") begin
            scan_mode = M_IDLE;
            emit_token(K_OP, tok_start, 2, 8'h00);
            held = 1'b1;
         end
         M_NUMBER: if (is_num(b)) begin
            tok_len = (tok_len == '1) ? tok_len : tok_len + 1'b1;
            held = 1'b1;
         end
         M_IDENT: if (is_letter(b) || is_num(b) || b == "_") begin
            kw_live = next_kw(kw_live, tok_len, b);
            tok_len = (tok_len == '1) ? tok_len : tok_len + 1'b1;
            held = 1'b1;
         end
         default: ;
      endcase
      if (!held) begin
         flush_token();
         if (scan_mode != M_HALT) open_token(b);
      end
   endfunction

   function automatic void lex_item(input logic [7:0] b, input logic eoi);
      step_count = 0;
      if (scan_mode != M_HALT) begin
         if (eoi) begin
            flush_token();
            if (scan_mode != M_HALT) begin
               add_token(ST_FINISH, K_LPAREN, '0, '0, 8'h00);
               scan_mode = M_HALT;
            end
         end else begin
            take_byte(b);
            byte_pos = byte_pos + 1'b1;
         end
      end
      if (step_count > 0) step_tokens[step_count - 1].last_result = 1'b1;
      for (int i = 0; i < step_count; i++) expected_tokens.push_back(step_tokens[i]);
   endfunction

   task automatic check_token(input lexer_rsp_type got);
      lexer_rsp_type want;
      if (expected_tokens.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_MAX)
            $display("unexpected beat: status %0d kind %0d start %0d len %0d bad %02h last %0d",
                     got.status, got.token_kind, got.start_offset, got.lexeme_length,
                     got.bad_char, got.last_result);
      end else begin
         want = expected_tokens.pop_front();
         if (got.status !== want.status || got.token_kind !== want.token_kind ||
             got.start_offset !== want.start_offset || got.lexeme_length !== want.lexeme_length ||
             got.bad_char !== want.bad_char || got.last_result !== want.last_result) begin
            error_count++;
            if (error_count <= REPORT_MAX) begin
               $write("mismatch: expected status %0d kind %0d start %0d len %0d ",
                      want.status, want.token_kind, want.start_offset, want.lexeme_length);
               $write("bad %02h last %0d, ", want.bad_char, want.last_result);
               $display("got status %0d kind %0d start %0d len %0d bad %02h last %0d",
                        got.status, got.token_kind, got.start_offset, got.lexeme_length,
                        got.bad_char, got.last_result);
            end
         end
      end
   endtask

   always @(negedge clock) begin
      pop <= !reset && (steady || $urandom_range(99) >= STALL_PCT);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("source_token_lexer_unit_tb NOT OK");
            $finish;
         end else if (pop && !empty) begin
            check_token(rsp_data);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat was taken.
   task automatic send_beat(input logic [7:0] b, input logic eoi);
      lexer_req_type beat;
      beat.text_byte = b;
      beat.end_of_input = eoi;
      while (!steady && $urandom_range(99) < STALL_PCT) begin
         push <= 1'b0;
         @(negedge clock);
      end
      req_data <= beat;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      lex_item(b, eoi);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   task automatic wait_drained();
      while (expected_tokens.size() != 0) @(negedge clock);
   endtask

   task automatic write_token_limit(input logic [LIMIT_BITS-1:0] value);
      push <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      token_limit = int'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_single_tokens();
      send_text("(){}=,;+*%!=");
   endtask

   task automatic test_words();
      send_text("while return int void whilex retu i_9 Zq 0 4096;");
   endtask

   task automatic test_slash_bang();
      send_text("1/2!x//c(\n!=a//\n/! ");
   endtask

   task automatic test_odd_bytes();
      logic [7:0] odd [12];
      odd = '{8'h00, 8'h7F, 8'h80, 8'hFF, "_", "@", 8'h09, 8'h0B, 8'h0C, 8'h0D, 8'h0A, "$"};
      foreach (odd[i]) send_beat(odd[i], 1'b0);
   endtask

   task automatic test_long_lexemes();
      repeat (270) send_beat(pick_char(digit_set), 1'b0);
      send_text(" return");
      repeat (255) send_beat(pick_char(word_set), 1'b0);
      send_beat(";", 1'b0);
   endtask

   task automatic test_random();
      int stop;
      int pick;
      int k;
      int cut;
      logic [7:0] c;
      bit paused;
      stop = sent_count + RANDOM_ITEMS;
      paused = 1'b0;
      while (sent_count < stop) begin
         steady = (stop - sent_count < 250) && (stop - sent_count > 130);
         if (!paused && stop - sent_count < 80) begin
            push <= 1'b0;
            wait_drained();
            @(negedge clock);
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 12) begin
            k = $urandom_range(KW_COUNT - 1);
            cut = $urandom_range(2);
            for (int i = 0; i < kw_text[k].len() - (cut == 0); i++) send_beat(kw_text[k][i], 1'b0);
            if (cut == 1) send_beat(pick_char(word_set), 1'b0);
         end else if (pick < 30) begin
            send_beat(pick_char(letter_set), 1'b0);
            repeat ($urandom_range(7)) send_beat(pick_char(word_set), 1'b0);
         end else if (pick < 42) begin
            repeat ($urandom_range(6, 1)) send_beat(pick_char(digit_set), 1'b0);
         end else if (pick < 62) begin
            send_beat(pick_char(punct_set), 1'b0);
         end else if (pick < 67) begin
            send_text("!=");
         end else if (pick < 72) begin
            send_beat(pick_char("/!"), 1'b0);
         end else if (pick < 78) begin
            send_text("//");
            repeat ($urandom_range(10)) begin
               do c = 8'($urandom_range(255)); while (c == 8'h0A);
               send_beat(c, 1'b0);
            end
            send_beat(8'h0A, 1'b0);
         end else if (pick < 85) begin
            repeat ($urandom_range(3, 1)) send_beat(pick_char(blank_set), 1'b0);
         end else begin
            send_beat(8'($urandom_range(255)), 1'b0);
         end
         if ($urandom_range(99) < 40) send_beat(pick_char(blank_set), 1'b0);
      end
      steady = 1'b0;
   endtask

   task automatic test_overflow();
      write_token_limit('0);
      send_text(" // tail\n q1");
      send_beat(8'($urandom_range(255)), 1'b1);
      send_text("(a");
      send_beat(8'h00, 1'b1);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_single_tokens();
      test_words();
      test_slash_bang();
      test_odd_bytes();
      write_token_limit(16'hFFFF);
      test_long_lexemes();
      write_token_limit(16'd3000);
      test_random();
      test_overflow();
      push <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("source_token_lexer_unit_tb OK");
      end else begin
         $display("source_token_lexer_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/stl_pkg.sv
hw/rtl/stl_queue.sv
hw/rtl/stl_front.sv
hw/rtl/stl_back.sv
hw/rtl/source_token_lexer_unit.sv
test/source_token_lexer_unit_tb.sv
